/* rtl/core/sympathetic_string_resonator_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the sympathetic string resonator unit
// Shared concurrent checks, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef SYMPATHETIC_STRING_RESONATOR_UNIT_ASSERT_SVH
`define SYMPATHETIC_STRING_RESONATOR_UNIT_ASSERT_SVH

// Check that cond holds in the same cycle as trig
`define SSR_ASSERT_NOW(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) else $error(msg);

// Check that cond holds in the cycle after trig
`define SSR_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

/* rtl/core/ssr_pkg.sv */
// ----------------------------------------------------------------------------
// ssr_pkg
// Constants, types and fixed-point helpers of the string resonator bank.
// ----------------------------------------------------------------------------
package ssr_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int MAX_STRINGS = 8;
  localparam int DELAY_DEPTH = 4096;
  localparam int IDX_W       = 12;
  localparam int STR_W       = 3;
  localparam int RING_AW     = STR_W + IDX_W;
  localparam int RING_DEPTH  = MAX_STRINGS * DELAY_DEPTH;

  localparam logic [15:0] LFSR_SEED    = 16'hACE1;
  localparam logic [15:0] LFSR_TAPS    = 16'hB400;
  localparam logic [15:0] NOISE_ON_MIN = 16'd656;
  localparam logic [15:0] WET_MIN      = 16'd33;
  localparam logic [16:0] FB_BASE      = 17'd65208;
  localparam logic [29:0] FB_SLOPE     = 30'd9830;
  localparam logic [14:0] C_BASE       = 15'd16384;
  localparam logic [29:0] C_SLOPE      = 30'd11469;
  localparam logic signed [12:0] NOISE_SCALE = 13'sd2621;
  localparam logic [3:0]  COUNT_MIN    = 4'd4;
  localparam logic [3:0]  COUNT_MAX    = 4'd8;

  typedef enum logic [2:0] {
    REG_DELAYS_LOW  = 3'd0,
    REG_DELAYS_HIGH = 3'd1,
    REG_STRING_CNT  = 3'd2,
    REG_DAMPING     = 3'd3,
    REG_NOISE_LEVEL = 3'd4,
    REG_WET_GAIN    = 3'd5,
    REG_STEREO      = 3'd6
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_NOISE, S_READ, S_LPMUL, S_LPADD, S_BLMUL,
    S_BLADD, S_FBMUL, S_WRITE, S_SCALE, S_DIVSET, S_DIV, S_FIN
  } ssr_state_t;

  // Round half away from zero, shift right by 16
  function automatic logic signed [47:0] rnd16(input logic signed [47:0] x);
    logic signed [47:0] half;
    half = 48'sd32768;
    if (x >= 0) return (x + half) >>> 16;
    return -((-x + half) >>> 16);
  endfunction

  // Round half away from zero, shift right by 25
  function automatic logic signed [47:0] rnd25(input logic signed [47:0] x);
    logic signed [47:0] half;
    half = 48'sd16777216;
    if (x >= 0) return (x + half) >>> 25;
    return -((-x + half) >>> 25);
  endfunction

  // Saturate to a signed sample
  function automatic logic signed [23:0] sat24(input logic signed [47:0] x);
    if (x > 48'sd8388607) return 24'sh7FFFFF;
    if (x < -48'sd8388608) return 24'sh800000;
    return x[23:0];
  endfunction

  // One step of the Galois noise register
  function automatic logic [15:0] lfsr_step(input logic [15:0] l);
    logic [15:0] n;
    n = l >> 1;
    if (l[0]) n = n ^ LFSR_TAPS;
    return n;
  endfunction

endpackage

/* rtl/core/sympathetic_string_resonator_unit.sv */
// Timing: one item at a time; a new input beat is taken only in idle, after the
//   previous result is loaded into the output register; muted items skip the strings.
// The pace is set by the per-string read-modify-write walk through the ring
//   memories and a 32-step divider.
// Reset: control, indexes, lowpass state and noise register clear at once;
//   the rings are not swept, per-string wrap flags make unwritten taps read 0.
// ----------------------------------------------------------------------------
// sympathetic_string_resonator_unit
// Bank of Karplus-Strong comb strings over two ring memories, stereo or mono Q1.23.
// ----------------------------------------------------------------------------
module sympathetic_string_resonator_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // [23:0] left_in, [47:24] right_in
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [23:0] left_out, [47:24] right_out
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data
);
  import ssr_pkg::*;

  ssr_state_t state, state_next;

  // configuration registers
  logic [47:0] delays_low, delays_high;
  logic [3:0]  string_count;
  logic [15:0] damping, noise_level, wet_gain;
  logic        stereo;

  // per-item registers
  logic signed [23:0] in_l, in_r;
  logic [3:0]  cnt;
  logic [STR_W-1:0] k;
  logic        noise_on, muted;
  logic [15:0] lfsr;
  logic signed [32:0] n1;
  logic signed [45:0] n2;
  logic signed [21:0] noise;
  logic [16:0] fb;
  logic [14:0] cf;

  // per-string state
  logic [IDX_W-1:0]   widx    [MAX_STRINGS];
  logic               wrapped [MAX_STRINGS];
  logic signed [23:0] lp_mem  [MAX_STRINGS];

  // ring memories
  logic signed [23:0] lring [RING_DEPTH];
  logic signed [23:0] rring [RING_DEPTH];
  logic signed [23:0] rdl, rdr;

  // string datapath
  logic [IDX_W-1:0]   wcur;
  logic               rd_valid;
  logic signed [23:0] tr_q, lp_cur;
  logic signed [41:0] lp_prod;
  logic signed [40:0] m1;
  logic signed [41:0] m2;
  logic signed [25:0] trp;
  logic signed [40:0] f1;
  logic signed [42:0] f2;
  logic signed [29:0] sum_l, sum_r;
  logic signed [46:0] p_l, p_r;
  logic [31:0] num_l, num_r;
  logic [2:0]  rem_l, rem_r;
  logic        neg_l, neg_r;
  logic [4:0]  iter;

  // control
  logic               in_beat, out_free, mem_we, rd_en;
  logic [95:0]        delays_all;
  logic [IDX_W-1:0]   dsel, dly, w_now, r_now;
  logic [RING_AW-1:0] raddr, waddr;
  logic signed [23:0] wl, wr;
  logic signed [23:0] lp_new;
  logic [3:0]         rsh_l, rsh_r;
  logic               ge_l, ge_r;
  logic [3:0]         cnt_in;

  assign in_beat  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // clamp the string count
  always_comb begin
    cnt_in = string_count;
    if (string_count < COUNT_MIN) cnt_in = COUNT_MIN;
    if (string_count > COUNT_MAX) cnt_in = COUNT_MAX;
  end

  // select and clamp the delay of the current string
  assign delays_all = {delays_high, delays_low};
  assign dsel  = delays_all[12*k +: 12];
  assign dly   = (dsel == '0) ? IDX_W'(1) : dsel;
  assign w_now = widx[k];
  assign r_now = w_now - dly;
  assign raddr = {k, r_now};
  assign waddr = {k, wcur};

  // new lowpass value and write-back samples
  assign lp_new = sat24(48'(lp_cur) + rnd16(48'(lp_prod)));
  assign wl = sat24(48'(in_l) + 48'(noise) + rnd16(48'(f1)));
  assign wr = sat24(48'(in_r) + 48'(noise) + rnd16(48'(f2)));

  // one restoring divide step on both channels
  assign rsh_l = {rem_l, num_l[31]};
  assign rsh_r = {rem_r, num_r[31]};
  assign ge_l  = rsh_l >= cnt;
  assign ge_r  = rsh_r >= cnt;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_beat) state_next = (wet_gain < WET_MIN) ? S_FIN : S_PREP;
      end
      S_PREP:   state_next = S_NOISE;
      S_NOISE:  state_next = S_READ;
      S_READ:   state_next = S_LPMUL;
      S_LPMUL:  state_next = S_LPADD;
      S_LPADD:  state_next = S_BLMUL;
      S_BLMUL:  state_next = S_BLADD;
      S_BLADD:  state_next = S_FBMUL;
      S_FBMUL:  state_next = S_WRITE;
      S_WRITE:  state_next = (4'(k) == cnt - 4'd1) ? S_SCALE : S_READ;
      S_SCALE:  state_next = S_DIVSET;
      S_DIVSET: state_next = S_DIV;
      S_DIV: begin
        if (iter == '0) state_next = S_FIN;
      end
      S_FIN: begin
        if (out_free) state_next = S_IDLE;
      end
      default:  state_next = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_tready = 1'b0;
    rd_en    = 1'b0;
    mem_we   = 1'b0;
    case (state)
      S_IDLE:  s_tready = 1'b1;
      S_READ:  rd_en    = 1'b1;
      S_WRITE: mem_we   = 1'b1;
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      delays_low   <= '0;
      delays_high  <= '0;
      string_count <= COUNT_MIN;
      damping      <= '0;
      noise_level  <= '0;
      wet_gain     <= 16'd32768;
      stereo       <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_DELAYS_LOW:  delays_low   <= cfg_data;
        REG_DELAYS_HIGH: delays_high  <= cfg_data;
        REG_STRING_CNT:  string_count <= cfg_data[3:0];
        REG_DAMPING:     damping      <= cfg_data[15:0];
        REG_NOISE_LEVEL: noise_level  <= cfg_data[15:0];
        REG_WET_GAIN:    wet_gain     <= cfg_data[15:0];
        REG_STEREO:      stereo       <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // ring memories: one read and one write port each
  always_ff @(posedge clk) begin
    if (mem_we) begin
      lring[waddr] <= wl;
      rring[waddr] <= wr;
    end
    if (rd_en) begin
      rdl <= lring[raddr];
      rdr <= rring[raddr];
    end
  end

  // per-string control state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_STRINGS; i++) begin
        widx[i]    <= '0;
        wrapped[i] <= 1'b0;
        lp_mem[i]  <= '0;
      end
      lfsr     <= LFSR_SEED;
      m_tvalid <= 1'b0;
      k        <= '0;
    end else begin
      // raise the output beat when loaded, drop it once taken
      if (state == S_FIN && out_free) m_tvalid <= 1'b1;
      else if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: k <= '0;
        S_PREP: begin
          if (noise_on) lfsr <= lfsr_step(lfsr);
        end
        S_LPADD: lp_mem[k] <= lp_new;
        S_WRITE: begin
          widx[k] <= wcur + IDX_W'(1);
          if (wcur == '1) wrapped[k] <= 1'b1;
          k <= k + STR_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        in_l     <= s_tdata[23:0];
        in_r     <= stereo ? s_tdata[47:24] : s_tdata[23:0];
        cnt      <= cnt_in;
        noise_on <= noise_level >= NOISE_ON_MIN;
        muted    <= wet_gain < WET_MIN;
        sum_l    <= '0;
        sum_r    <= '0;
      end
      S_PREP: begin
        // step noise and derive loop gain and cutoff from damping
        if (noise_on)
          n1 <= ($signed({1'b0, lfsr_step(lfsr)}) - 17'sd32768) *
                $signed({1'b0, noise_level});
        else
          n1 <= '0;
        fb <= FB_BASE - 17'((FB_SLOPE * 30'(damping) + 30'd32768) >> 16);
        cf <= C_BASE - 15'((C_SLOPE * 30'(damping) + 30'd32768) >> 16);
      end
      S_NOISE: n2 <= n1 * NOISE_SCALE;
      S_READ: begin
        noise    <= 22'(rnd25(48'(n2)));
        wcur     <= w_now;
        lp_cur   <= lp_mem[k];
        rd_valid <= wrapped[k] || (dly <= w_now);
      end
      S_LPMUL: begin
        // unwritten ring entries read as zero
        lp_prod <= (25'(rd_valid ? rdl : 24'sd0) - 25'(lp_cur)) *
                   $signed({2'b0, cf});
        tr_q    <= rd_valid ? rdr : 24'sd0;
      end
      S_LPADD: lp_cur <= lp_new;
      S_BLMUL: begin
        m1 <= tr_q * $signed({2'b0, cf});
        m2 <= lp_cur * $signed(18'd65536 - {3'b0, cf});
      end
      S_BLADD: trp <= 26'(rnd16(48'(m1) + 48'(m2)));
      S_FBMUL: begin
        f1 <= lp_cur * $signed({1'b0, fb});
        f2 <= trp * $signed({1'b0, fb});
      end
      S_WRITE: begin
        sum_l <= sum_l + 30'(lp_cur);
        sum_r <= sum_r + 30'(trp);
      end
      S_SCALE: begin
        p_l <= sum_l * $signed({1'b0, wet_gain});
        p_r <= sum_r * $signed({1'b0, wet_gain});
      end
      S_DIVSET: begin
        // magnitude plus half the divisor, then the power-of-two part
        neg_l <= p_l < 0;
        neg_r <= p_r < 0;
        num_l <= 32'((48'(p_l < 0 ? -p_l : p_l) + 48'(cnt) * 48'd16384) >> 15);
        num_r <= 32'((48'(p_r < 0 ? -p_r : p_r) + 48'(cnt) * 48'd16384) >> 15);
        rem_l <= '0;
        rem_r <= '0;
        iter  <= '1;
      end
      S_DIV: begin
        rem_l <= 3'(ge_l ? rsh_l - cnt : rsh_l);
        rem_r <= 3'(ge_r ? rsh_r - cnt : rsh_r);
        num_l <= {num_l[30:0], ge_l};
        num_r <= {num_r[30:0], ge_r};
        iter  <= iter - 5'd1;
      end
      S_FIN: begin
        // saturate and load the output register
        if (out_free) begin
          if (muted) begin
            m_tdata <= '0;
          end else begin
            m_tdata[23:0] <= neg_l ? sat24(-48'(num_l)) : sat24(48'(num_l));
            if (stereo)
              m_tdata[47:24] <= neg_r ? sat24(-48'(num_r)) : sat24(48'(num_r));
            else
              m_tdata[47:24] <= '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

`include "sympathetic_string_resonator_unit_assert.svh"

  `SSR_ASSERT_NOW(a_lfsr_live, 1'b1, lfsr != 16'h0000, "noise register stuck at zero")
  `SSR_ASSERT_NOW(a_string_range, state == S_WRITE, 4'(k) < cnt, "string index past count")
  `SSR_ASSERT_NOW(a_mono_right, m_tvalid && !stereo, m_tdata[47:24] == 24'h0, "mono right not zero")
  `SSR_ASSERT_NEXT(a_mute_path, in_beat && wet_gain < WET_MIN, state == S_FIN, "muted item not bypassed")

endmodule
